// File: rtl/sample_without_replacement_top_macros.svh
// assertion macros for the sample-without-replacement block
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef SAMPLE_WITHOUT_REPLACEMENT_TOP_MACROS_SVH
`define SAMPLE_WITHOUT_REPLACEMENT_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// consequent must hold in the same cycle as the antecedent
`define SWR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sample_without_replacement: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define SWR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sample_without_replacement: next-cycle check failed");

`else

`define SWR_ASSERT_SAME(label, ante, cons)
`define SWR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/swr_pkg.sv
// shared types and constants for the sample-without-replacement block
// no dependencies
package swr_pkg;

    // fixed field widths
    localparam int RAND_W  = 32;
    localparam int CFG_W   = 13;
    localparam int PICK_W  = 12;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POPULATION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE     = 1'b1;

    // register reset values
    localparam logic [CFG_W-1:0] POPULATION_RESET = 13'd4096;
    localparam logic [CFG_W-1:0] SAMPLE_RESET     = 13'd1;

    // sample tag kept beside each remap entry
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // per-draw flags worked out by the front
    typedef struct packed {
        logic start;
        logic last;
    } swr_flags_t;

    // one result beat
    typedef struct packed {
        logic [PICK_W-1:0] picked_index;
        logic              last_of_sample;
    } swr_result_t;

endpackage

// File: rtl/swr_front.sv
// front end: configuration registers, draw counting and fixed-point scaling
// depends on swr_pkg
module swr_front #(
    parameter int MAX_POPULATION = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [swr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swr_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [swr_pkg::RAND_W-1:0]      random_fraction,
    input  logic                            restart,
    output logic                            fe_valid,
    input  logic                            fe_ready,
    output logic [$clog2(MAX_POPULATION)-1:0] fe_x,
    output logic [$clog2(MAX_POPULATION)-1:0] fe_tail,
    output swr_pkg::swr_flags_t             fe_flags
);
    import swr_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POPULATION);
    localparam int CNT_W  = $clog2(MAX_POPULATION + 1);
    localparam int CW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int PROD_W = RAND_W + CNT_W;
    localparam logic [CW-1:0] MAX_W = CW'(MAX_POPULATION);
    localparam logic [CW-1:0] ONE_W = CW'(1);

    logic [CFG_W-1:0]  population_reg;
    logic [CFG_W-1:0]  sample_reg;
    logic [CNT_W-1:0]  draw_count_reg;
    logic [CNT_W-1:0]  draw_count_next;
    logic              stage_valid_reg;
    logic [RAND_W-1:0] u_reg;
    logic [CNT_W-1:0]  m_reg;
    logic [CNT_W-1:0]  m_next;
    swr_flags_t        flags_reg;
    swr_flags_t        flags_next;

    logic [CW-1:0]     pop_w;
    logic [CW-1:0]     samp_w;
    logic [CW-1:0]     n_w;
    logic [CW-1:0]     k_w;
    logic [CNT_W-1:0]  base;
    logic [PROD_W-1:0] product;
    logic              accept;
    logic              push;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            population_reg <= POPULATION_RESET;
            sample_reg     <= SAMPLE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_POPULATION: population_reg <= cfg_data;
                CFG_SAMPLE:     sample_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // effective n and k, clamped to their legal ranges
    always_comb
    begin
        pop_w  = CW'(population_reg);
        samp_w = CW'(sample_reg);
        if (pop_w == '0)
            n_w = ONE_W;
        else if (pop_w > MAX_W)
            n_w = MAX_W;
        else
            n_w = pop_w;
        if (samp_w == '0)
            k_w = ONE_W;
        else if (samp_w > n_w)
            k_w = n_w;
        else
            k_w = samp_w;
    end

    // classify the beat: sample start, remaining population, last draw
    always_comb
    begin
        flags_next.start = restart || (CW'(draw_count_reg) >= k_w);
        base             = flags_next.start ? '0 : draw_count_reg;
        m_next           = CNT_W'(n_w) - base;
        draw_count_next  = base + CNT_W'(1);
        flags_next.last  = (CW'(draw_count_next) == k_w);
    end

    assign push     = stage_valid_reg && fe_ready;
    assign in_ready = !stage_valid_reg || fe_ready;
    assign accept   = in_valid && in_ready;

    // draw counter and stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_count_reg  <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                draw_count_reg <= draw_count_next;
            if (accept)
                stage_valid_reg <= 1'b1;
            else if (push)
                stage_valid_reg <= 1'b0;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            u_reg     <= random_fraction;
            m_reg     <= m_next;
            flags_reg <= flags_next;
        end
    end

    // x = floor(u * m / 2^32), registered by the queue
    assign product  = PROD_W'(u_reg) * PROD_W'(m_reg);
    assign fe_x     = product[RAND_W +: IDX_W];
    assign fe_tail  = IDX_W'(m_reg - CNT_W'(1));
    assign fe_flags = flags_reg;
    assign fe_valid = stage_valid_reg;

endmodule

// File: rtl/swr_queue.sv
// short queue that parts the front end from the back end
// depends on swr_pkg
module swr_queue #(
    parameter int WIDTH = 26
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_pop,
    output logic [WIDTH-1:0] out_data
);
    import swr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;
    assign out_data  = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_data;
    end

endmodule

// File: rtl/swr_back.sv
// back end: remap memory with per-sample tags, lookup, update and result register
// depends on swr_pkg
module swr_back #(
    parameter int MAX_POPULATION = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  logic [$clog2(MAX_POPULATION)-1:0] q_x,
    input  logic [$clog2(MAX_POPULATION)-1:0] q_tail,
    input  swr_pkg::swr_flags_t               q_flags,
    output logic                              clearing,
    output logic                              out_valid,
    input  logic                              out_ready,
    output swr_pkg::swr_result_t              out_result
);
    import swr_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POPULATION);
    localparam int WORD_W = IDX_W + EPOCH_W;
    localparam int PW     = (IDX_W > PICK_W) ? IDX_W : PICK_W;
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(MAX_POPULATION - 1);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_READ  = 3'b010,
        ST_WRITE = 3'b100
    } swr_back_state_t;

    swr_back_state_t   state_reg;
    swr_back_state_t   state_next;
    logic [IDX_W-1:0]  clr_addr_reg;
    logic [IDX_W-1:0]  clr_addr_next;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [EPOCH_W-1:0] epoch_next;
    logic [IDX_W-1:0]  cur_x_reg;
    logic [IDX_W-1:0]  cur_tail_reg;
    logic              cur_last_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    swr_result_t       out_result_reg;

    logic [WORD_W-1:0] mem [MAX_POPULATION];
    logic [WORD_W-1:0] rd_x_reg;
    logic [WORD_W-1:0] rd_tail_reg;
    logic              mem_re;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    logic              x_hit;
    logic              tail_hit;
    logic [IDX_W-1:0]  pick;
    logic [IDX_W-1:0]  tail_val;
    logic [PW-1:0]     pick_ext;
    logic              load_out;

    // an entry counts only if tagged with the current sample
    assign x_hit    = (rd_x_reg[IDX_W +: EPOCH_W] == epoch_reg);
    assign tail_hit = (rd_tail_reg[IDX_W +: EPOCH_W] == epoch_reg);
    assign pick     = x_hit ? rd_x_reg[IDX_W-1:0] : cur_x_reg;
    assign tail_val = tail_hit ? rd_tail_reg[IDX_W-1:0] : cur_tail_reg;
    assign pick_ext = PW'(pick);

    // sequencer: clearing pass, read both entries, then write and emit
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        epoch_next     = epoch_reg;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = cur_x_reg;
        mem_wdata      = {epoch_reg, tail_val};
        q_pop          = 1'b0;
        load_out       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_READ;
                    if (epoch_reg == EPOCH_MAX)
                        epoch_next = '0;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + IDX_W'(1);
                end
            end
            ST_READ:
            begin
                if (q_valid)
                begin
                    if (q_flags.start && (epoch_reg == EPOCH_MAX))
                    begin
                        // tags run out: sweep the memory before this sample
                        state_next    = ST_CLEAR;
                        clr_addr_next = '0;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        q_pop      = 1'b1;
                        state_next = ST_WRITE;
                        if (q_flags.start)
                            epoch_next = epoch_reg + EPOCH_W'(1);
                    end
                end
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    mem_we     = 1'b1;
                    load_out   = 1'b1;
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers; tag zero is left by the sweep and never current
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            epoch_reg     <= EPOCH_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            epoch_reg     <= epoch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working copy of the popped draw
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_x_reg    <= q_x;
            cur_tail_reg <= q_tail;
            cur_last_reg <= q_flags.last;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_result_reg.picked_index   <= pick_ext[PICK_W-1:0];
            out_result_reg.last_of_sample <= cur_last_reg;
        end
    end

    // remap memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
        begin
            rd_x_reg    <= mem[q_x];
            rd_tail_reg <= mem[q_tail];
        end
    end

    assign clearing   = (state_reg == ST_CLEAR);
    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

// File: rtl/sample_without_replacement_top.sv
// Sparse Fisher-Yates sampler: each input beat carries a 32-bit random fraction
// and draws one distinct index from 0..n-1, k draws per sample; the k-th draw is
// flagged on m_tlast and the next beat (or any beat with restart set) opens a new
// sample. The back end handles each draw in a read state and a write state set by
// its remap memory: the read state reads the drawn entry and the tail entry, the
// write state writes the drawn entry and loads the result register, and waits
// while the output stalls. After reset, and again before every 255th new sample,
// a clearing pass sweeps every entry of the remap memory; meanwhile input beats
// collect in the front stage and the four-entry queue and then stall.
// Configuration may be written at any time the block is idle.
// depends on swr_pkg, swr_front, swr_queue, swr_back and the assertion macro header
`include "sample_without_replacement_top_macros.svh"

module sample_without_replacement_top #(
    parameter int MAX_POPULATION = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [swr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swr_pkg::CFG_W-1:0]     cfg_data,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [31:0] random_fraction
    input  logic [0:0]                    s_tuser,   // [0] restart
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // [11:0] picked_index, [15:12] zero
    output logic                          m_tlast    // last_of_sample
);
    import swr_pkg::*;

    localparam int IDX_W = $clog2(MAX_POPULATION);
    localparam int Q_W   = 2 * IDX_W + $bits(swr_flags_t);

    logic             fe_valid;
    logic             fe_ready;
    logic [IDX_W-1:0] fe_x;
    logic [IDX_W-1:0] fe_tail;
    swr_flags_t       fe_flags;
    logic [Q_W-1:0]   q_in_data;
    logic [Q_W-1:0]   q_out_data;
    logic             q_valid;
    logic             q_pop;
    logic [IDX_W-1:0] q_x;
    logic [IDX_W-1:0] q_tail;
    swr_flags_t       q_flags;
    logic             clearing;
    swr_result_t      result;

    // front end
    swr_front #(
        .MAX_POPULATION (MAX_POPULATION)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .random_fraction (s_tdata),
        .restart         (s_tuser[0]),
        .fe_valid        (fe_valid),
        .fe_ready        (fe_ready),
        .fe_x            (fe_x),
        .fe_tail         (fe_tail),
        .fe_flags        (fe_flags)
    );

    // queue between the two halves
    assign q_in_data = {fe_x, fe_tail, fe_flags};

    swr_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_data   (q_in_data),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_data  (q_out_data)
    );

    assign q_x     = q_out_data[Q_W-1 -: IDX_W];
    assign q_tail  = q_out_data[$bits(swr_flags_t) +: IDX_W];
    assign q_flags = q_out_data[$bits(swr_flags_t)-1:0];

    // back end
    swr_back #(
        .MAX_POPULATION (MAX_POPULATION)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_x        (q_x),
        .q_tail     (q_tail),
        .q_flags    (q_flags),
        .clearing   (clearing),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // output packing
    assign m_tdata = {{(16 - PICK_W){1'b0}}, result.picked_index};
    assign m_tlast = result.last_of_sample;

    // checks
    `SWR_ASSERT_NEXT(a_restart_opens_sample, s_tvalid && s_tready && s_tuser[0], fe_valid && fe_flags.start)
    `SWR_ASSERT_NEXT(a_front_holds_when_blocked, fe_valid && !fe_ready, fe_valid && $stable(q_in_data))
    `SWR_ASSERT_SAME(a_no_draw_while_clearing, clearing, !q_pop)

endmodule

// File: verif/testbench.sv
// self-checking testbench for sample_without_replacement_top: streams random
// fractions through the sampler and checks every picked index against a predictor
// depends on swr_pkg and the rtl of sample_without_replacement_top
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import swr_pkg::*;

    localparam int          MAX_POP       = 4096;
    localparam int          RANDOM_ITEMS  = 1200;
    localparam int          LONG_HOLD     = 400;
    localparam int          SETTLE_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT   = 800000;

    // one draw request and one predicted pick
    typedef struct {
        logic [RAND_W-1:0] fraction;
        logic              restart;
    } draw_req_t;

    typedef struct {
        logic [PICK_W-1:0] picked;
        logic              last_flag;
    } pick_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_POPULATION;
    logic [CFG_W-1:0]     cfg_data = '0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [31:0] random_fraction
    logic [0:0]  s_tuser = '0;   // [0] restart

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [11:0] picked_index, [15:12] zero
    logic        m_tlast;        // last_of_sample

    // stimulus and expectation stores
    draw_req_t   draw_backlog[$];
    pick_t       pending_picks[$];
    int unsigned picks_queued = 0;
    int unsigned picks_checked = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_seq = 0;

    // predictor copy of the registers and the sparse remap table
    logic [CFG_W-1:0]  population_copy = POPULATION_RESET;
    logic [CFG_W-1:0]  sample_copy = SAMPLE_RESET;
    logic [PICK_W-1:0] remap_val[MAX_POP];
    int unsigned       remap_tag[MAX_POP];
    int unsigned       sample_tag = 1;
    int unsigned       drawn_in_sample = 0;

    // driver and monitor working variables
    draw_req_t   next_draw;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    pick_t       want;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned ready_window = 0;
    int unsigned ready_mode = 0;

    sample_without_replacement_top #(
        .MAX_POPULATION(MAX_POP)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // one sparse fisher-yates draw; a sample tag per entry stands in for the valid bits
    function automatic pick_t predict_pick(input logic [RAND_W-1:0] fraction,
                                           input logic restart);
        int unsigned       n;
        int unsigned       k;
        int unsigned       m;
        int unsigned       x;
        int unsigned       tail;
        logic [63:0]       product;
        logic [PICK_W-1:0] tail_val;
        pick_t             res;
        n = population_copy;
        if (n < 1) n = 1;
        if (n > MAX_POP) n = MAX_POP;
        k = sample_copy;
        if (k < 1) k = 1;
        if (k > n) k = n;
        // new sample: forget every remap entry
        if (restart || drawn_in_sample >= k)
        begin
            sample_tag++;
            drawn_in_sample = 0;
        end
        m = n - drawn_in_sample;
        product = 64'(fraction) * 64'(m);
        x = product[63:32];
        if (x >= m) x = m - 1;
        tail = m - 1;
        res.picked = (remap_tag[x] == sample_tag) ? remap_val[x] : x[PICK_W-1:0];
        tail_val = (remap_tag[tail] == sample_tag) ? remap_val[tail] : tail[PICK_W-1:0];
        remap_val[x] = tail_val;
        remap_tag[x] = sample_tag;
        drawn_in_sample++;
        res.last_flag = (drawn_in_sample == k);
        return res;
    endfunction

    // input side: bursts of beats separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (draw_backlog.size() > 0)
            begin
                next_draw = draw_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= next_draw.fraction;
                s_tuser <= next_draw.restart;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // predict on every accepted input beat
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            pending_picks.insert(pending_picks.size(), predict_pick(s_tdata, s_tuser[0]));
    end

    // output side: check result beats, stall on random windows and long holds
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_seen = 0;
            hold_left = 0;
            ready_window = 0;
            ready_mode = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_picks.size() == 0)
                begin
                    $error("result beat with nothing expected: tdata %h tlast %b",
                           m_tdata, m_tlast);
                    error_count++;
                end
                else
                begin
                    want = pending_picks.pop_front();
                    picks_checked++;
                    if (m_tdata[PICK_W-1:0] !== want.picked)
                    begin
                        $error("picked_index: expected %0d, actual %0d",
                               want.picked, m_tdata[PICK_W-1:0]);
                        error_count++;
                    end
                    if (m_tlast !== want.last_flag)
                    begin
                        $error("last_of_sample: expected %b, actual %b",
                               want.last_flag, m_tlast);
                        error_count++;
                    end
                    if (m_tdata[15:PICK_W] !== '0)
                    begin
                        $error("tdata padding: expected 0, actual %h", m_tdata[15:PICK_W]);
                        error_count++;
                    end
                end
            end
            // long hold requested by the stimulus sequence
            if (hold_seen != hold_seq)
            begin
                hold_seen = hold_seq;
                hold_left = LONG_HOLD;
            end
            if (ready_window == 0)
            begin
                ready_window = $urandom_range(8, 64);
                ready_mode = $urandom_range(0, 3);
            end
            else
            begin
                ready_window--;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (ready_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: errors");
        $finish;
    end

    task automatic queue_draw(input logic [RAND_W-1:0] fraction, input logic restart);
        draw_req_t req;
        req.fraction = fraction;
        req.restart = restart;
        draw_backlog.insert(draw_backlog.size(), req);
        picks_queued++;
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_POPULATION)
            population_copy = value[CFG_W-1:0];
        else
            sample_copy = value[CFG_W-1:0];
    endtask

    // wait until every queued draw has been checked, then let the block settle
    task automatic drain;
        while (picks_checked != picks_queued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // stimulus sequence
    initial
    begin
        int unsigned random_total;
        int unsigned phase;
        int unsigned n;
        int unsigned k;
        int unsigned count;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values, tail of the full range and a restart
        queue_draw(32'h0000_0000, 1'b0);
        queue_draw(32'hFFFF_FFFF, 1'b0);
        queue_draw(32'h8000_0000, 1'b1);
        drain();

        // tiny population drained by tail draws, then automatic and forced restarts
        set_register(CFG_POPULATION, 5);
        set_register(CFG_SAMPLE, 5);
        repeat (5) queue_draw(32'hFFFF_FFFF, 1'b0);
        queue_draw(32'h0000_0000, 1'b0);
        queue_draw(32'h7FFF_FFFF, 1'b1);
        drain();

        // out-of-range registers are clamped
        set_register(CFG_POPULATION, 8191);
        set_register(CFG_SAMPLE, 0);
        queue_draw(32'hFFFF_FFFF, 1'b0);
        queue_draw(32'h0000_0001, 1'b0);
        drain();
        set_register(CFG_POPULATION, 0);
        set_register(CFG_SAMPLE, 8191);
        queue_draw(32'hFFFF_FFFF, 1'b0);
        queue_draw(32'h0000_0000, 1'b0);
        drain();

        // lowering k below the draws made starts a new sample
        set_register(CFG_POPULATION, 16);
        set_register(CFG_SAMPLE, 10);
        repeat (5) queue_draw($urandom, 1'b0);
        drain();
        set_register(CFG_SAMPLE, 3);
        queue_draw($urandom, 1'b0);
        drain();
        // lowering n below the draws made does the same
        set_register(CFG_SAMPLE, 10);
        repeat (3) queue_draw($urandom, 1'b0);
        drain();
        set_register(CFG_POPULATION, 3);
        repeat (2) queue_draw($urandom, 1'b0);
        drain();

        // random phases, mostly whole samples with the odd restart
        random_total = 0;
        phase = 0;
        while (random_total < RANDOM_ITEMS)
        begin
            case ((phase == 0) ? 4 : $urandom_range(0, 4))
                0:
                begin
                    n = $urandom_range(1, 16);
                    k = n;
                    count = n * $urandom_range(3, 8);
                end
                1:
                begin
                    n = $urandom_range(2, 64);
                    k = $urandom_range(1, n);
                    count = 100;
                end
                2:
                begin
                    n = MAX_POP;
                    k = $urandom_range(100, 250);
                    count = k + $urandom_range(0, 50);
                end
                3:
                begin
                    n = $urandom_range(0, 8191);
                    k = $urandom_range(0, 8191);
                    count = 80;
                end
                default:
                begin
                    // one draw per sample to wrap the tag at first, else one sample
                    n = (phase == 0) ? MAX_POP : $urandom_range(2, 300);
                    k = (phase == 0) ? 1 : n;
                    count = (phase == 0) ? 300 : n;
                end
            endcase
            set_register(CFG_POPULATION, n);
            set_register(CFG_SAMPLE, k);
            if (phase == 0 || phase == 1 || phase == 4)
                hold_seq++;
            repeat (count) queue_draw($urandom, ($urandom_range(0, 39) == 0));
            random_total += count;
            drain();
            phase++;
        end

        if (pending_picks.size() != 0)
        begin
            $error("%0d expected picks never arrived", pending_picks.size());
            error_count++;
        end
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
